FILE: rtl/core/trkm_pkg.sv
// Shared constants, key and command types for the two-run key merge.
`timescale 1ns / 1ps
`default_nettype none
package trkm_pkg;

   localparam int RUN_DEPTH = 32;
   localparam int KEY_BYTES = 64;
   localparam int WORD_W = 64;
   localparam int KEY_WORDS = 8;
   localparam int CNT_W = $clog2(RUN_DEPTH + 1);
   localparam int ADDR_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] merge_key_type;

   typedef struct packed {
      logic          side;
      logic          write;
      logic          finish;
      merge_key_type key;
   } cmd_type;

   // Bytes of word w that take part in the key compare.
   function automatic logic [WORD_W-1:0] word_mask(input int w);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (8 * w + b < KEY_BYTES) begin
            m[WORD_W-1-8*b -: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/trkm_front.sv
// Input side: accept request transfers and turn them into store commands.
`timescale 1ns / 1ps
`default_nettype none
module trkm_front (
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_run_side,
   input  wire logic                       req_key_present,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_0,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_1,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_2,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_3,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_4,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_5,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_6,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_7,
   input  wire logic                       req_end_of_load,
   input  wire logic                       queue_full,
   output logic                            push,
   output trkm_pkg::cmd_type               push_cmd
);

   assign req_ready = !queue_full;

   // Drop transfers that neither store a key nor end the load.
   assign push = req_valid && !queue_full && (req_key_present || req_end_of_load);

   always_comb begin
      push_cmd.side   = req_run_side;
      push_cmd.write  = req_key_present;
      push_cmd.finish = req_end_of_load;
      push_cmd.key[0] = req_key_word_0;
      push_cmd.key[1] = req_key_word_1;
      push_cmd.key[2] = req_key_word_2;
      push_cmd.key[3] = req_key_word_3;
      push_cmd.key[4] = req_key_word_4;
      push_cmd.key[5] = req_key_word_5;
      push_cmd.key[6] = req_key_word_6;
      push_cmd.key[7] = req_key_word_7;
   end

endmodule
`default_nettype wire

FILE: rtl/core/trkm_cmd_fifo.sv
// Short command queue between the input side and the merge engine.
`timescale 1ns / 1ps
`default_nettype none
module trkm_cmd_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire trkm_pkg::cmd_type push_cmd,
   output logic                   full,
   output logic                   pop_valid,
   output trkm_pkg::cmd_type      pop_cmd,
   input  wire logic              pop
);

   localparam logic [trkm_pkg::CMD_CNT_W-1:0] DEPTH_CNT =
      trkm_pkg::CMD_CNT_W'(trkm_pkg::CMD_DEPTH);
   localparam logic [trkm_pkg::CMD_PTR_W-1:0] LAST_PTR =
      trkm_pkg::CMD_PTR_W'(trkm_pkg::CMD_DEPTH - 1);

   trkm_pkg::cmd_type                 entry_ff [trkm_pkg::CMD_DEPTH];
   logic [trkm_pkg::CMD_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [trkm_pkg::CMD_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [trkm_pkg::CMD_CNT_W-1:0]    count_ff, count_in;
   logic                              do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/trkm_back.sv
// Merge engine: run stores, merge sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module trkm_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire trkm_pkg::cmd_type cmd,
   output logic                   cmd_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output trkm_pkg::merge_key_type rsp_key,
   output logic                   rsp_from_right,
   output logic                   rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD   = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_SEL  = 2'd3;

   localparam logic [trkm_pkg::CNT_W-1:0] FULL_CNT =
      trkm_pkg::CNT_W'(trkm_pkg::RUN_DEPTH);

   trkm_pkg::merge_key_type          left_mem  [trkm_pkg::RUN_DEPTH];
   trkm_pkg::merge_key_type          right_mem [trkm_pkg::RUN_DEPTH];
   trkm_pkg::merge_key_type          left_rd_ff, right_rd_ff;

   logic [1:0]                       state_ff, state_in;
   logic [trkm_pkg::CNT_W-1:0]       lc_ff, lc_in, rc_ff, rc_in;
   logic [trkm_pkg::CNT_W-1:0]       i_ff, i_in, j_ff, j_in;
   logic [trkm_pkg::KEY_WORDS-1:0]   gt_ff, gt_in, eq_ff, eq_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   trkm_pkg::merge_key_type          out_key_ff, out_key_in;
   logic                             from_right_ff, from_right_in;
   logic                             last_ff, last_in;

   logic                             pop, wr_left, wr_right;
   logic                             out_free, load, take_right, key_gt, is_last;
   logic [trkm_pkg::CNT_W:0]         total_new, total_now, emitted_next;
   logic [trkm_pkg::WORD_W-1:0]      lw, rw;

   assign cmd_ready      = (state_ff == ST_IDLE);
   assign pop            = cmd_ready && cmd_valid;
   assign wr_left        = pop && cmd.write && !cmd.side && (lc_ff != FULL_CNT);
   assign wr_right       = pop && cmd.write && cmd.side && (rc_ff != FULL_CNT);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key        = out_key_ff;
   assign rsp_from_right = from_right_ff;
   assign rsp_last       = last_ff;

   always_comb begin
      for (int w = 0; w < trkm_pkg::KEY_WORDS; w++) begin
         lw = left_rd_ff[w] & trkm_pkg::word_mask(w);
         rw = right_rd_ff[w] & trkm_pkg::word_mask(w);
         gt_in[w] = (lw > rw);
         eq_in[w] = (lw == rw);
      end
   end

   always_comb begin
      key_gt = 1'b0;
      for (int w = trkm_pkg::KEY_WORDS - 1; w >= 0; w--) begin
         if (!eq_ff[w]) begin
            key_gt = gt_ff[w];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      lc_in         = wr_left ? lc_ff + 1'b1 : lc_ff;
      rc_in         = wr_right ? rc_ff + 1'b1 : rc_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      out_key_in    = out_key_ff;
      from_right_in = from_right_ff;
      last_in       = last_ff;
      load          = 1'b0;
      out_free      = !rsp_valid_ff || rsp_ready;
      total_new     = {1'b0, lc_in} + {1'b0, rc_in};
      total_now     = {1'b0, lc_ff} + {1'b0, rc_ff};
      emitted_next  = {1'b0, i_ff} + {1'b0, j_ff} + 1'b1;
      is_last       = (emitted_next == total_now);
      if (i_ff >= lc_ff) begin
         take_right = 1'b1;
      end else if (j_ff >= rc_ff) begin
         take_right = 1'b0;
      end else begin
         take_right = key_gt;
      end
      case (state_ff)
         ST_IDLE: begin
            if (pop && cmd.finish && (total_new != '0)) begin
               state_in = ST_RD;
               i_in     = '0;
               j_in     = '0;
            end
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_SEL;
         end
         ST_SEL: begin
            if (out_free) begin
               load          = 1'b1;
               out_key_in    = take_right ? right_rd_ff : left_rd_ff;
               from_right_in = take_right;
               last_in       = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
                  lc_in    = '0;
                  rc_in    = '0;
                  i_in     = '0;
                  j_in     = '0;
               end else begin
                  state_in = ST_RD;
                  if (take_right) begin
                     j_in = j_ff + 1'b1;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lc_ff        <= '0;
         rc_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         rc_ff        <= rc_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gt_ff         <= gt_in;
      eq_ff         <= eq_in;
      out_key_ff    <= out_key_in;
      from_right_ff <= from_right_in;
      last_ff       <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_left) begin
         left_mem[lc_ff[trkm_pkg::ADDR_W-1:0]] <= cmd.key;
      end
      if (wr_right) begin
         right_mem[rc_ff[trkm_pkg::ADDR_W-1:0]] <= cmd.key;
      end
      left_rd_ff  <= left_mem[i_ff[trkm_pkg::ADDR_W-1:0]];
      right_rd_ff <= right_mem[j_ff[trkm_pkg::ADDR_W-1:0]];
   end

   a_merge_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (total_now != '0))
      else $error("merge running with both runs empty");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (i_ff <= lc_ff) && (j_ff <= rc_ff))
      else $error("merge index beyond run length");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (lc_ff <= FULL_CNT) && (rc_ff <= FULL_CNT))
      else $error("run count beyond store depth");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (load && is_last) |=> (state_ff == ST_IDLE) && (lc_ff == '0) && (rc_ff == '0))
      else $error("runs not cleared after final key");

endmodule
`default_nettype wire

FILE: rtl/core/two_run_key_merge_top.sv
// Top level of the two-run key merge: input side, command queue, merge engine.
// Loading: one key per cycle while the merge engine is idle; a request passes through the command queue to the stores.
// Merge: starts once the end-of-load transfer leaves the command queue; each key passes
// through store read, word compare and select before the next key is read.
// Requests queue in a two-entry command queue while a merge runs, then stall.
// Synchronous active-high reset empties the queue and both runs; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module two_run_key_merge_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_run_side,
   input  wire logic                        req_key_present,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_0,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_1,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_2,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_3,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_4,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_5,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_6,
   input  wire logic [trkm_pkg::WORD_W-1:0] req_key_word_7,
   input  wire logic                        req_end_of_load,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [trkm_pkg::WORD_W-1:0]      rsp_out_word_0,
   output logic [trkm_pkg::WORD_W-1:0]      rsp_out_word_1,
   output logic [trkm_pkg::WORD_W-1:0]      rsp_out_word_2,
   output logic [trkm_pkg::WORD_W-1:0]      rsp_out_word_3,
   output logic [trkm_pkg::WORD_W-1:0]      rsp_out_word_4,
   output logic [trkm_pkg::WORD_W-1:0]      rsp_out_word_5,
   output logic [trkm_pkg::WORD_W-1:0]      rsp_out_word_6,
   output logic [trkm_pkg::WORD_W-1:0]      rsp_out_word_7,
   output logic                             rsp_came_from_right,
   output logic                             rsp_last_of_merge
);

   logic                    queue_full, push, pop_valid, pop;
   trkm_pkg::cmd_type       push_cmd, pop_cmd;
   trkm_pkg::merge_key_type rsp_key;

   trkm_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_run_side    (req_run_side),
      .req_key_present (req_key_present),
      .req_key_word_0  (req_key_word_0),
      .req_key_word_1  (req_key_word_1),
      .req_key_word_2  (req_key_word_2),
      .req_key_word_3  (req_key_word_3),
      .req_key_word_4  (req_key_word_4),
      .req_key_word_5  (req_key_word_5),
      .req_key_word_6  (req_key_word_6),
      .req_key_word_7  (req_key_word_7),
      .req_end_of_load (req_end_of_load),
      .queue_full      (queue_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   trkm_cmd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop       (pop)
   );

   trkm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (pop_valid),
      .cmd            (pop_cmd),
      .cmd_ready      (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key        (rsp_key),
      .rsp_from_right (rsp_came_from_right),
      .rsp_last       (rsp_last_of_merge)
   );

   assign rsp_out_word_0 = rsp_key[0];
   assign rsp_out_word_1 = rsp_key[1];
   assign rsp_out_word_2 = rsp_key[2];
   assign rsp_out_word_3 = rsp_key[3];
   assign rsp_out_word_4 = rsp_key[4];
   assign rsp_out_word_5 = rsp_key[5];
   assign rsp_out_word_6 = rsp_key[6];
   assign rsp_out_word_7 = rsp_key[7];

endmodule
`default_nettype wire
